// ===== src/lfd_pkg.sv =====
// Shared types, constants and checksum helper for the LIN frame decoder.
package lfd_pkg;

  localparam int          MAX_DATA_BYTES = 8;
  localparam logic [7:0]  SYNC_BYTE      = 8'h55;
  localparam logic [7:0]  ID_MASK        = 8'h3F;
  localparam logic [7:0]  ID_MASTER_REQ  = 8'h3C;
  localparam logic [7:0]  ID_SLAVE_RESP  = 8'h3D;
  localparam logic [7:0]  SUM_SEED       = 8'h00;
  localparam logic [1:0]  VER_RESET      = 2'd2;

  typedef enum logic [2:0] {
    ST_WAIT  = 3'd0,
    ST_SYNC  = 3'd1,
    ST_PID   = 3'd2,
    ST_DATA0 = 3'd3,
    ST_DATA  = 3'd4
  } state_t;

  typedef enum logic [2:0] {
    KIND_BREAK = 3'd0,
    KIND_SYNC  = 3'd1,
    KIND_PID   = 3'd2,
    KIND_DATA  = 3'd3,
    KIND_CSUM  = 3'd4,
    KIND_MAYBE = 3'd5
  } kind_t;

  typedef struct packed {
    logic       is_break;
    logic [7:0] rx_byte;
    logic       rx_framing_error;
  } item_t;

  typedef struct packed {
    kind_t      field_kind;
    logic [7:0] field_value;
    logic [3:0] data_count;
    logic       framing_flag;
    logic       sync_error;
    logic       checksum_error;
    logic       packet_start;
    logic       packet_end;
  } result_t;

  // 8-bit add with end-around carry
  function automatic logic [7:0] sum_add(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    return s[8] ? (s[7:0] + 8'd1) : s[7:0];
  endfunction

endpackage

// ===== src/lfd_in_stage.sv =====
// Input register for received characters.
module lfd_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lfd_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output lfd_pkg::item_t item
);

  logic           valid_r, valid_nxt;
  lfd_pkg::item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== src/lfd_parser.sv =====
// Frame parse state machine, byte counter and running checksum.
module lfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  lfd_pkg::item_t   item,
  input  logic             enhanced,
  output logic             res_hit,
  output lfd_pkg::result_t res
);

  lfd_pkg::state_t state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      csum;
  logic [7:0]      id;
  logic            classic_id;
  logic            at_max;
  logic            sync_ok;

  assign csum       = ~sum_r;
  assign id         = item.rx_byte & lfd_pkg::ID_MASK;
  assign classic_id = (id == lfd_pkg::ID_MASTER_REQ) || (id == lfd_pkg::ID_SLAVE_RESP);
  assign at_max     = cnt_r >= 4'(lfd_pkg::MAX_DATA_BYTES);
  assign sync_ok    = item.rx_byte == lfd_pkg::SYNC_BYTE;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (item.is_break) begin
      state_nxt = lfd_pkg::ST_SYNC;
    end else begin
      unique case (state_r)
        lfd_pkg::ST_SYNC:  state_nxt = sync_ok ? lfd_pkg::ST_PID : lfd_pkg::ST_WAIT;
        lfd_pkg::ST_PID:   state_nxt = lfd_pkg::ST_DATA0;
        lfd_pkg::ST_DATA0: state_nxt = lfd_pkg::ST_DATA;
        lfd_pkg::ST_DATA:  state_nxt = at_max ? lfd_pkg::ST_WAIT : lfd_pkg::ST_DATA;
        default:           state_nxt = lfd_pkg::ST_WAIT;
      endcase
    end
  end

  // outputs, counter and checksum
  always_comb begin
    res                  = '0;
    res.field_kind       = lfd_pkg::KIND_DATA;
    res.field_value      = item.rx_byte;
    res.framing_flag     = item.rx_framing_error;
    res_hit              = 1'b1;
    cnt_nxt              = cnt_r;
    sum_nxt              = sum_r;
    if (item.is_break) begin
      res.field_kind   = lfd_pkg::KIND_BREAK;
      res.field_value  = 8'h00;
      res.packet_start = 1'b1;
      cnt_nxt          = 4'd0;
    end else begin
      unique case (state_r)
        lfd_pkg::ST_SYNC: begin
          res.field_kind = lfd_pkg::KIND_SYNC;
          res.sync_error = !sync_ok;
        end
        lfd_pkg::ST_PID: begin
          res.field_kind = lfd_pkg::KIND_PID;
          sum_nxt = (enhanced && !classic_id) ?
                    lfd_pkg::sum_add(lfd_pkg::SUM_SEED, item.rx_byte) : lfd_pkg::SUM_SEED;
        end
        lfd_pkg::ST_DATA0: begin
          res.field_kind = lfd_pkg::KIND_DATA;
          sum_nxt = lfd_pkg::sum_add(enhanced ? sum_r : lfd_pkg::SUM_SEED, item.rx_byte);
          cnt_nxt = 4'd1;
        end
        lfd_pkg::ST_DATA: begin
          if (at_max) begin
            res.field_kind     = lfd_pkg::KIND_CSUM;
            res.checksum_error = csum != item.rx_byte;
            res.packet_end     = 1'b1;
            cnt_nxt            = 4'd0;
          end else begin
            res.field_kind = (csum == item.rx_byte) ? lfd_pkg::KIND_MAYBE : lfd_pkg::KIND_DATA;
            sum_nxt        = lfd_pkg::sum_add(sum_r, item.rx_byte);
            cnt_nxt        = cnt_r + 4'd1;
          end
        end
        default: begin
          res_hit = 1'b0;
        end
      endcase
    end
    res.data_count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfd_pkg::ST_WAIT;
      cnt_r   <= 4'd0;
      sum_r   <= lfd_pkg::SUM_SEED;
    end else if (advance) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== src/lfd_out_stage.sv =====
// Result register toward the output stream.
module lfd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  lfd_pkg::result_t res,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output lfd_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  lfd_pkg::result_t res_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== src/lin_frame_decoder.sv =====
// LIN frame decoder top level.
// Classifies received LIN characters (break or byte) as break, sync, PID, data,
// checksum or data-or-checksum, keeping the running LIN checksum (enhanced in
// versions 2 and 3 except for identifiers 0x3C/0x3D). One character is accepted
// per clock while the output is not stalled; each is held in the input register,
// then the parse logic writes its result to the result register. Bytes seen while
// waiting for a break give no result. Writes to cfg_wdata must happen while idle.
module lin_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,      // lin_version
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,       // [7:0] rx_byte, [8] rx_framing_error, rest zero
  input  logic        in_tuser,       // is_break
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,      // [7:0] field_value, [11:8] data_count,
                                      // [12] framing_flag, [13] sync_error,
                                      // [14] checksum_error, [15] packet_start
  output logic [2:0]  out_tuser,      // field_kind
  output logic        out_tlast       // packet_end
);

  logic [1:0]       ver_r;
  lfd_pkg::item_t   in_item;
  lfd_pkg::item_t   item;
  logic             item_valid;
  logic             can_load;
  logic             advance;
  logic             res_hit;
  lfd_pkg::result_t res;
  lfd_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r <= lfd_pkg::VER_RESET;
    end else if (cfg_we) begin
      ver_r <= cfg_wdata;
    end
  end

  assign in_item.is_break         = in_tuser;
  assign in_item.rx_byte          = in_tdata[7:0];
  assign in_item.rx_framing_error = in_tdata[8];

  assign advance = item_valid && can_load;

  lfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lfd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (item),
    .enhanced (ver_r[1]),
    .res_hit  (res_hit),
    .res      (res)
  );

  lfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_hit),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.packet_start, out_res.checksum_error, out_res.sync_error,
                      out_res.framing_flag, out_res.data_count, out_res.field_value};
  assign out_tuser = out_res.field_kind;
  assign out_tlast = out_res.packet_end;

  a_csum_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> out_tuser == lfd_pkg::KIND_CSUM)
    else $error("checksum error on non-checksum field");

  a_start_is_break: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15] == (out_tuser == lfd_pkg::KIND_BREAK)))
    else $error("packet_start does not match break kind");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:8] <= 4'(lfd_pkg::MAX_DATA_BYTES))
    else $error("data count out of range");

  a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[11:8] == 4'd0)
    else $error("frame end with nonzero count");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_valid && out_tvalid && !out_tready)
    else $error("input stalled without backpressure");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for lin_frame_decoder: LIN character stream against a field predictor.
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_FIELDS   = 250;

  class lin_field_board;
    logic [1:0]       version;
    lfd_pkg::state_t  st;
    logic [3:0]       count;
    logic [7:0]       acc;
    lfd_pkg::result_t fields_q[$];
    int               errors;
    int               shown;
    int               checked;
    int               closed;
    int               maybes;

    function new();
      version = lfd_pkg::VER_RESET;
      st      = lfd_pkg::ST_WAIT;
      count   = '0;
      acc     = lfd_pkg::SUM_SEED;
      errors  = 0;
      shown   = 0;
      checked = 0;
      closed  = 0;
      maybes  = 0;
    endfunction

    function logic [7:0] add_carry(logic [7:0] a, logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 9'd255) s = s - 9'd255;
      return s[7:0];
    endfunction

    function logic [7:0] csum_now();
      return ~acc;
    endfunction

    function void report(string msg);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("ERROR @%0t: %s", $realtime, msg);
      end
    endfunction

    function string fmt(lfd_pkg::result_t r);
      return $sformatf(
        "kind=%0d val=%02h cnt=%0d fe=%0b sync=%0b csum=%0b start=%0b end=%0b",
        r.field_kind, r.field_value, r.data_count, r.framing_flag,
        r.sync_error, r.checksum_error, r.packet_start, r.packet_end);
    endfunction

    // returns 1 when the character yields a field
    function bit note_char(bit brk, logic [7:0] b, bit fe);
      lfd_pkg::result_t r;
      bit               enh;
      bit               classic;
      logic [7:0]       id;
      r              = '0;
      r.field_kind   = lfd_pkg::KIND_DATA;
      r.field_value  = b;
      r.framing_flag = fe;
      enh            = (version >= 2'd2);
      if (brk) begin
        r.field_kind   = lfd_pkg::KIND_BREAK;
        r.field_value  = 8'h00;
        r.packet_start = 1'b1;
        count          = '0;
        st             = lfd_pkg::ST_SYNC;
      end else begin
        case (st)
          lfd_pkg::ST_SYNC: begin
            r.field_kind = lfd_pkg::KIND_SYNC;
            if (b == lfd_pkg::SYNC_BYTE) begin
              st = lfd_pkg::ST_PID;
            end else begin
              r.sync_error = 1'b1;
              st           = lfd_pkg::ST_WAIT;
            end
          end
          lfd_pkg::ST_PID: begin
            id           = b & lfd_pkg::ID_MASK;
            classic      = (id == lfd_pkg::ID_MASTER_REQ) || (id == lfd_pkg::ID_SLAVE_RESP);
            r.field_kind = lfd_pkg::KIND_PID;
            acc          = (enh && !classic) ? add_carry(lfd_pkg::SUM_SEED, b)
                                             : lfd_pkg::SUM_SEED;
            st           = lfd_pkg::ST_DATA0;
          end
          lfd_pkg::ST_DATA0: begin
            if (!enh) acc = lfd_pkg::SUM_SEED;
            acc   = add_carry(acc, b);
            count = 4'd1;
            st    = lfd_pkg::ST_DATA;
          end
          lfd_pkg::ST_DATA: begin
            if (count >= lfd_pkg::MAX_DATA_BYTES) begin
              r.field_kind     = lfd_pkg::KIND_CSUM;
              r.checksum_error = (~acc != b);
              r.packet_end     = 1'b1;
              count            = '0;
              st               = lfd_pkg::ST_WAIT;
              closed++;
            end else begin
              if (~acc == b) begin
                r.field_kind = lfd_pkg::KIND_MAYBE;
                maybes++;
              end
              acc   = add_carry(acc, b);
              count = count + 4'd1;
            end
          end
          default: begin
            st = lfd_pkg::ST_WAIT;
            return 0;
          end
        endcase
      end
      r.data_count = count;
      fields_q.insert(fields_q.size(), r);
      return 1;
    endfunction

    function void check_field(lfd_pkg::result_t got);
      lfd_pkg::result_t exp;
      string            bad;
      if (fields_q.size() == 0) begin
        report($sformatf("unexpected field: %s", fmt(got)));
        return;
      end
      exp = fields_q.pop_front();
      checked++;
      bad = "";
      if (got.field_kind     !== exp.field_kind)     bad = {bad, " kind"};
      if (got.field_value    !== exp.field_value)    bad = {bad, " value"};
      if (got.data_count     !== exp.data_count)     bad = {bad, " count"};
      if (got.framing_flag   !== exp.framing_flag)   bad = {bad, " framing"};
      if (got.sync_error     !== exp.sync_error)     bad = {bad, " sync_err"};
      if (got.checksum_error !== exp.checksum_error) bad = {bad, " csum_err"};
      if (got.packet_start   !== exp.packet_start)   bad = {bad, " start"};
      if (got.packet_end     !== exp.packet_end)     bad = {bad, " end"};
      if (bad != "")
        report($sformatf("field mismatch (%s)\n  exp %s\n  got %s", bad, fmt(exp), fmt(got)));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_wdata  = 2'd0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'd0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  lin_field_board sb = new();

  bit quiet    = 0;
  bit hold_req = 0;
  int tx_gap_pct   = 10;
  int rx_stall_pct = 10;
  int chars_sent   = 0;
  int fields_due   = 0;
  int idle_cycles  = 0;

  lin_frame_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  function automatic bit fe_rand();
    return ($urandom_range(0, 9) == 0);
  endfunction

  task automatic send_char(bit brk, logic [7:0] b, bit fe);
    in_tvalid <= 1'b1;
    in_tuser  <= brk;
    in_tdata  <= {7'd0, fe, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (sb.note_char(brk, b, fe)) fields_due++;
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic set_version(logic [1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.fields_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.version = v;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_char(1'b0, 8'($urandom), fe_rand());
  endtask

  task automatic send_frame();
    logic [7:0] pid;
    logic [7:0] b;
    int         n;
    send_char(1'b1, 8'($urandom), fe_rand());
    if ($urandom_range(0, 9) == 0) begin
      send_char(1'b0, 8'($urandom), fe_rand());
      return;
    end
    send_char(1'b0, lfd_pkg::SYNC_BYTE, fe_rand());
    pid = 8'($urandom);
    if ($urandom_range(0, 4) == 0)
      pid[5:0] = $urandom_range(0, 1) ? lfd_pkg::ID_MASTER_REQ[5:0]
                                      : lfd_pkg::ID_SLAVE_RESP[5:0];
    send_char(1'b0, pid, fe_rand());
    n = $urandom_range(0, 1) ? lfd_pkg::MAX_DATA_BYTES
                             : $urandom_range(0, lfd_pkg::MAX_DATA_BYTES);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) return;  // next break cuts the frame short
      case ($urandom_range(0, 9))
        0, 1:    b = sb.csum_now();
        2:       b = 8'hFF;
        3:       b = 8'h00;
        default: b = 8'($urandom);
      endcase
      send_char(1'b0, b, fe_rand());
    end
    if (n == lfd_pkg::MAX_DATA_BYTES)
      send_char(1'b0, ($urandom_range(0, 3) != 0) ? sb.csum_now() : 8'($urandom), fe_rand());
  endtask

  task automatic directed();
    send_char(1'b0, 8'hA5, 1'b1);                   // ignored while waiting
    send_char(1'b1, 8'hFF, 1'b1);
    send_char(1'b0, 8'h54, 1'b1);                   // bad sync
    send_char(1'b0, lfd_pkg::SYNC_BYTE, 1'b0);      // ignored again
    send_char(1'b1, 8'h00, 1'b0);
    send_char(1'b0, lfd_pkg::SYNC_BYTE, 1'b0);
    send_char(1'b0, 8'hFC, 1'b0);                   // master request id, classic sum
    send_char(1'b0, 8'hFF, 1'b0);
    send_char(1'b0, sb.csum_now(), 1'b1);           // possible checksum
    send_char(1'b0, 8'h00, 1'b0);
    send_char(1'b1, 8'h3C, 1'b0);                   // break mid-frame
    send_char(1'b0, lfd_pkg::SYNC_BYTE, 1'b1);
    send_char(1'b0, 8'h7D, 1'b0);                   // slave response id
    repeat (7) send_char(1'b0, 8'hFF, 1'b0);
    send_char(1'b0, sb.csum_now(), 1'b0);
    send_char(1'b0, sb.csum_now(), 1'b0);           // forced checksum, good
    send_char(1'b1, 8'h00, 1'b0);
    send_char(1'b0, lfd_pkg::SYNC_BYTE, 1'b0);
    send_char(1'b0, 8'h3F, 1'b1);                   // enhanced sum seeded with pid
    repeat (8) send_char(1'b0, 8'h80, 1'b0);
    send_char(1'b0, 8'h00, 1'b1);                   // forced checksum, bad
  endtask

  initial begin
    logic [1:0] versions[4];
    int         target;
    versions = '{2'd1, 2'd0, 2'd3, 2'd2};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    for (int ph = 0; ph < 4; ph++) begin
      set_version(versions[ph]);
      target = fields_due + PHASE_FIELDS;
      while (fields_due < target) begin
        if (ph == 0 && fields_due > 60) hold_req = 1;
        if (ph == 3 && fields_due > target - 120) quiet = 1;
        if ($urandom_range(0, 11) == 0) send_noise();
        else                            send_frame();
        if ($urandom_range(0, 19) == 0) tx_gap_pct = pick_pct();
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.fields_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fields_q.size() != 0)
      sb.report($sformatf("%0d fields never arrived", sb.fields_q.size()));
    $display("Sent %0d characters over versions 2,1,0,3,2; checked %0d fields.",
             chars_sent, sb.checked);
    $display("%0d frames closed by forced checksum, %0d possible checksums, %0d errors.",
             sb.closed, sb.maybes, sb.errors);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off, none at the end
  initial begin
    int cyc;
    bit hold_done;
    cyc       = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 200 == 0) rx_stall_pct = pick_pct();
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lfd_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.field_kind     = lfd_pkg::kind_t'(out_tuser);
      got.field_value    = out_tdata[7:0];
      got.data_count     = out_tdata[11:8];
      got.framing_flag   = out_tdata[12];
      got.sync_error     = out_tdata[13];
      got.checksum_error = out_tdata[14];
      got.packet_start   = out_tdata[15];
      got.packet_end     = out_tlast;
      sb.check_field(got);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
